FILE: rtl/core/xsp_pkg.sv
package xsp_pkg;

  // object number width, counts saturate one bit above it
  localparam int OBJ_BITS  = 23;
  localparam int NUM_BITS  = OBJ_BITS + 1;
  localparam int OFF_BITS  = 34;
  localparam int GEN_BITS  = 17;
  localparam int BYTE_BITS = 8;
  localparam int COL_BITS  = 5;

  localparam logic [NUM_BITS-1:0] NUM_LIMIT  = NUM_BITS'((64'd1 << OBJ_BITS) + 64'd1);
  localparam logic [NUM_BITS:0]   NUM_SPAN   = (NUM_BITS + 1)'(64'd1 << OBJ_BITS);

  // stream packing
  localparam int TDATA_FIELDS = OBJ_BITS + OFF_BITS + GEN_BITS + BYTE_BITS;
  localparam int OUT_TDATA_W  = ((TDATA_FIELDS + 7) / 8) * 8;
  localparam int IN_TDATA_W   = 8;
  localparam int STAT_BITS    = 3;

  // characters
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;

  localparam logic [COL_BITS-1:0] HDR_LEN = 5'd4;

  // result kinds
  typedef enum logic [STAT_BITS-1:0] {
    ST_ENTRY      = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_BAD_HEADER = 3'd2,
    ST_BAD_SUBSEC = 3'd3,
    ST_BAD_ENTRY  = 3'd4
  } status_t;

  typedef struct packed {
    logic                 section_start;
    logic [BYTE_BITS-1:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [OBJ_BITS-1:0]  object_number;
    logic [OFF_BITS-1:0]  byte_offset;
    logic [GEN_BITS-1:0]  generation_number;
    logic [BYTE_BITS-1:0] use_mark;
    status_t              status;
    logic                 last;
  } result_t;

  // expected header text, one character per column
  function automatic logic [7:0] head_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h78;  // x
      2'd1:    c = 8'h72;  // r
      2'd2:    c = 8'h65;  // e
      default: c = 8'h66;  // f
    endcase
    return c;
  endfunction

  function automatic logic is_dig(input logic [7:0] b);
    return (b >= CH_0) && (b <= CH_9);
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SP) || (b == CH_TAB);
  endfunction

  function automatic logic [3:0] dig_val(input logic [7:0] b);
    logic [7:0] d;
    d = b - CH_0;
    return d[3:0];
  endfunction

  // decimal accumulate with saturation at the limit
  function automatic logic [NUM_BITS-1:0] sat_acc(input logic [NUM_BITS-1:0] acc,
                                                  input logic [3:0] d);
    logic [NUM_BITS+3:0] w;
    logic [NUM_BITS+3:0] v;
    w = {4'b0, acc};
    v = (w << 3) + (w << 1) + (NUM_BITS + 4)'(d);
    return (v > (NUM_BITS + 4)'(NUM_LIMIT)) ? NUM_LIMIT : v[NUM_BITS-1:0];
  endfunction

endpackage

FILE: rtl/core/xsp_in_stage.sv
module xsp_in_stage
  import xsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tuser,
  input  logic                  adv,
  output logic                  item_valid,
  output item_t                 item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  take;

  // free slot or slot drained this cycle, never while in reset
  assign in_tready  = rst_n && (!valid_r || adv);
  assign take       = in_tvalid && in_tready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (take) begin
      item_r.data_byte     <= in_tdata[BYTE_BITS-1:0];
      item_r.section_start <= in_tuser;
    end
  end

endmodule

FILE: rtl/core/xsp_step.sv
module xsp_step
  import xsp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv,
  input  item_t   item,
  output logic    res_valid,
  output result_t res
);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_SUBSEC = 3'd2,
    PH_ENTRY  = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  // subsection line positions
  localparam logic [COL_BITS-1:0] SUB_LEAD  = 5'd0;
  localparam logic [COL_BITS-1:0] SUB_FIRST = 5'd1;
  localparam logic [COL_BITS-1:0] SUB_GAP   = 5'd2;
  localparam logic [COL_BITS-1:0] SUB_COUNT = 5'd3;
  localparam logic [COL_BITS-1:0] SUB_TRAIL = 5'd4;
  localparam logic [COL_BITS-1:0] SUB_CR    = 5'd5;

  // entry columns
  localparam logic [COL_BITS-1:0] COL_OFF_FIRST = 5'd0;
  localparam logic [COL_BITS-1:0] COL_OFF_LAST  = 5'd9;
  localparam logic [COL_BITS-1:0] COL_OFF_SEP   = 5'd10;
  localparam logic [COL_BITS-1:0] COL_GEN_FIRST = 5'd11;
  localparam logic [COL_BITS-1:0] COL_GEN_LAST  = 5'd15;
  localparam logic [COL_BITS-1:0] COL_GEN_SEP   = 5'd16;
  localparam logic [COL_BITS-1:0] COL_USE       = 5'd17;
  localparam logic [COL_BITS-1:0] COL_TERM      = 5'd18;
  localparam logic [COL_BITS-1:0] COL_END       = 5'd19;

  phase_t               phase_r, phase_nxt;
  logic [COL_BITS-1:0]  column_r, column_nxt;
  logic                 line_bad_r, line_bad_nxt;
  logic [NUM_BITS-1:0]  first_r, first_nxt;
  logic [NUM_BITS-1:0]  total_r, total_nxt;
  logic [NUM_BITS-1:0]  index_r, index_nxt;
  logic [OFF_BITS-1:0]  off_acc_r, off_acc_nxt;
  logic [GEN_BITS-1:0]  gen_acc_r, gen_acc_nxt;
  logic [1:0]           dend_r, dend_nxt;
  logic [BYTE_BITS-1:0] use_r, use_nxt;
  logic [BYTE_BITS-1:0] term_r, term_nxt;

  always_comb begin
    logic [7:0]          b;
    logic [3:0]          d;
    logic [NUM_BITS:0]   sum;
    logic [NUM_BITS-1:0] idx_inc;
    logic                sub_ok;
    logic                term_ok;

    b = item.data_byte;
    d = dig_val(b);

    phase_nxt    = phase_r;
    column_nxt   = column_r;
    line_bad_nxt = line_bad_r;
    first_nxt    = first_r;
    total_nxt    = total_r;
    index_nxt    = index_r;
    off_acc_nxt  = off_acc_r;
    gen_acc_nxt  = gen_acc_r;
    dend_nxt     = dend_r;
    use_nxt      = use_r;
    term_nxt     = term_r;
    res_valid    = 1'b0;
    res          = '0;

    sum     = {1'b0, first_r} + {1'b0, total_r};
    idx_inc = index_r + 1'b1;
    sub_ok  = 1'b0;
    term_ok = 1'b0;

    // section start restarts from a cleared state
    if (item.section_start) begin
      phase_nxt    = PH_HEADER;
      column_nxt   = '0;
      line_bad_nxt = 1'b0;
      first_nxt    = '0;
      total_nxt    = '0;
      index_nxt    = '0;
      off_acc_nxt  = '0;
      gen_acc_nxt  = '0;
      dend_nxt     = '0;
      use_nxt      = '0;
      term_nxt     = '0;
    end

    case (phase_nxt)
      // header line "xref" plus carriage returns
      PH_HEADER: begin
        if (b == CH_LF) begin
          if (!line_bad_nxt && column_nxt == HDR_LEN) begin
            phase_nxt    = PH_SUBSEC;
            column_nxt   = '0;
            line_bad_nxt = 1'b0;
          end else begin
            phase_nxt  = PH_DONE;
            res_valid  = 1'b1;
            res.status = ST_BAD_HEADER;
            res.last   = 1'b1;
          end
        end else if (column_nxt < HDR_LEN) begin
          if (b == head_char(column_nxt[1:0])) begin
            column_nxt = column_nxt + 1'b1;
          end else begin
            line_bad_nxt = 1'b1;
          end
        end else if (b != CH_CR) begin
          line_bad_nxt = 1'b1;
        end
      end

      // subsection line "start count"
      PH_SUBSEC: begin
        if (b == CH_LF) begin
          sub_ok = !line_bad_nxt && column_nxt >= SUB_COUNT && column_nxt <= SUB_CR;
          if (!sub_ok || sum > NUM_SPAN) begin
            phase_nxt  = PH_DONE;
            res_valid  = 1'b1;
            res.status = ST_BAD_SUBSEC;
            res.last   = 1'b1;
          end else if (total_nxt == '0) begin
            phase_nxt  = PH_DONE;
            res_valid  = 1'b1;
            res.status = ST_EMPTY;
            res.last   = 1'b1;
          end else begin
            phase_nxt    = PH_ENTRY;
            index_nxt    = '0;
            column_nxt   = '0;
            line_bad_nxt = 1'b0;
            off_acc_nxt  = '0;
            gen_acc_nxt  = '0;
            dend_nxt     = '0;
            use_nxt      = '0;
            term_nxt     = '0;
          end
        end else begin
          case (column_nxt)
            SUB_LEAD: begin
              if (is_dig(b)) begin
                first_nxt  = sat_acc(first_nxt, d);
                column_nxt = SUB_FIRST;
              end else if (!is_blank(b)) begin
                line_bad_nxt = 1'b1;
              end
            end
            SUB_FIRST: begin
              if (is_dig(b)) begin
                first_nxt = sat_acc(first_nxt, d);
              end else if (is_blank(b)) begin
                column_nxt = SUB_GAP;
              end else begin
                line_bad_nxt = 1'b1;
              end
            end
            SUB_GAP: begin
              if (is_dig(b)) begin
                total_nxt  = sat_acc(total_nxt, d);
                column_nxt = SUB_COUNT;
              end else if (!is_blank(b)) begin
                line_bad_nxt = 1'b1;
              end
            end
            SUB_COUNT: begin
              if (is_dig(b)) begin
                total_nxt = sat_acc(total_nxt, d);
              end else if (is_blank(b)) begin
                column_nxt = SUB_TRAIL;
              end else if (b == CH_CR) begin
                column_nxt = SUB_CR;
              end else begin
                line_bad_nxt = 1'b1;
              end
            end
            SUB_TRAIL: begin
              if (b == CH_CR) begin
                column_nxt = SUB_CR;
              end else if (!is_blank(b)) begin
                line_bad_nxt = 1'b1;
              end
            end
            default: begin
              if (b != CH_CR) begin
                line_bad_nxt = 1'b1;
              end
            end
          endcase
        end
      end

      // fixed 20-byte entry
      PH_ENTRY: begin
        if (column_nxt == COL_END) begin
          term_ok = (term_nxt == CH_SP && (b == CH_CR || b == CH_LF)) ||
                    (term_nxt == CH_CR && b == CH_LF);
          res_valid = 1'b1;
          if (line_bad_nxt || !term_ok) begin
            phase_nxt  = PH_DONE;
            res.status = ST_BAD_ENTRY;
            res.last   = 1'b1;
          end else begin
            res.object_number     = OBJ_BITS'(first_nxt + index_nxt);
            res.byte_offset       = off_acc_nxt;
            res.generation_number = gen_acc_nxt;
            res.use_mark          = use_nxt;
            res.status            = ST_ENTRY;
            res.last              = (idx_inc == total_nxt);
            index_nxt             = idx_inc;
            if (idx_inc >= total_nxt) begin
              phase_nxt = PH_DONE;
            end
            column_nxt   = '0;
            line_bad_nxt = 1'b0;
            off_acc_nxt  = '0;
            gen_acc_nxt  = '0;
            dend_nxt     = '0;
            use_nxt      = '0;
            term_nxt     = '0;
          end
        end else begin
          if (column_nxt == COL_OFF_FIRST || column_nxt == COL_GEN_FIRST) begin
            if (is_dig(b)) begin
              if (column_nxt == COL_OFF_FIRST) begin
                off_acc_nxt = OFF_BITS'(d);
              end else begin
                gen_acc_nxt = GEN_BITS'(d);
              end
            end else begin
              line_bad_nxt = 1'b1;
            end
          end else if (column_nxt <= COL_OFF_LAST) begin
            if (!dend_nxt[0] && is_dig(b)) begin
              off_acc_nxt = OFF_BITS'((off_acc_nxt << 3) + (off_acc_nxt << 1) +
                                      OFF_BITS'(d));
            end else begin
              dend_nxt[0] = 1'b1;
            end
          end else if (column_nxt == COL_OFF_SEP || column_nxt == COL_GEN_SEP) begin
            if (b != CH_SP) begin
              line_bad_nxt = 1'b1;
            end
          end else if (column_nxt <= COL_GEN_LAST) begin
            if (!dend_nxt[1] && is_dig(b)) begin
              gen_acc_nxt = GEN_BITS'((gen_acc_nxt << 3) + (gen_acc_nxt << 1) +
                                      GEN_BITS'(d));
            end else begin
              dend_nxt[1] = 1'b1;
            end
          end else if (column_nxt == COL_USE) begin
            use_nxt = b;
            if (b == CH_SP) begin
              line_bad_nxt = 1'b1;
            end
          end else if (column_nxt == COL_TERM) begin
            term_nxt = b;
          end
          column_nxt = column_nxt + 1'b1;
        end
      end

      default: ;
    endcase
  end

  // parser state, updated once per consumed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      column_r   <= '0;
      line_bad_r <= 1'b0;
      first_r    <= '0;
      total_r    <= '0;
      index_r    <= '0;
      off_acc_r  <= '0;
      gen_acc_r  <= '0;
      dend_r     <= '0;
      use_r      <= '0;
      term_r     <= '0;
    end else if (adv) begin
      phase_r    <= phase_nxt;
      column_r   <= column_nxt;
      line_bad_r <= line_bad_nxt;
      first_r    <= first_nxt;
      total_r    <= total_nxt;
      index_r    <= index_nxt;
      off_acc_r  <= off_acc_nxt;
      gen_acc_r  <= gen_acc_nxt;
      dend_r     <= dend_nxt;
      use_r      <= use_nxt;
      term_r     <= term_nxt;
    end
  end

  // error and empty results always close the section
  a_err_last : assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.status != ST_ENTRY |-> res.last)
    else $error("non-entry result without last");

  // a closing result leaves the parser finished
  a_last_done : assert property (@(posedge clk) disable iff (!rst_n)
    adv && res_valid && res.last |=> phase_r == PH_DONE)
    else $error("section closed but parser not finished");

  // entry index stays below the count while entries are parsed
  a_index_range : assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ENTRY |-> index_r < total_r)
    else $error("entry index beyond subsection count");

  // entry column stays inside the fixed record
  a_col_range : assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ENTRY |-> column_r <= COL_END)
    else $error("entry column out of range");

endmodule

FILE: rtl/core/xsp_out_reg.sv
module xsp_out_reg
  import xsp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  result_t                res,
  output logic                   can_take,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [STAT_BITS-1:0]   out_tuser,
  output logic                   out_tlast
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  // slot free or being emptied this cycle
  assign can_take = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  // field packing, lowest field first
  assign out_tvalid = valid_r;
  assign out_tdata  = OUT_TDATA_W'({res_r.use_mark, res_r.generation_number,
                                    res_r.byte_offset, res_r.object_number});
  assign out_tuser  = res_r.status;
  assign out_tlast  = res_r.last;

endmodule

FILE: rtl/core/xref_section_parser.sv
// channel   direction  payload
// in_*      input      tdata: data_byte; tuser: section_start
// out_*     output     tdata: object_number, byte_offset, generation_number,
//                      use_mark; tuser: status; tlast: last
//
// one byte per cycle sustained while out_* is not stalled; a request goes
// input register -> parse logic -> result register, and a byte that ends
// a result loads it into the result register when the parse step takes it
// rst_n is synchronous, active low, holds in_tready low, and leaves the
// parser idle until a byte flagged as section start
// a stall on the result side holds the parse stage; the input register
// still takes one request while the result register waits
module xref_section_parser
  import xsp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] data_byte
  input  logic                   in_tuser,   // [0] section_start
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // object_number, byte_offset,
                                             // generation_number, use_mark, zero pad
  output logic [STAT_BITS-1:0]   out_tuser,  // [2:0] status
  output logic                   out_tlast
);

  logic    item_valid;
  item_t   item;
  logic    adv;
  logic    can_take;
  logic    res_valid;
  result_t res;

  // parse step runs when a byte is held and the result slot can take it
  assign adv = item_valid && can_take;

  xsp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .adv        (adv),
    .item_valid (item_valid),
    .item       (item)
  );

  xsp_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  xsp_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (adv && res_valid),
    .res        (res),
    .can_take   (can_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
